@@ design/kct_pkg.sv @@
// ----------------------------------------------------------------------------
// kct_pkg: shared types and constants of the keyed count table
// Holds the field widths, the request codes, the sequencer states and the
// result bundle of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package kct_pkg;

  localparam int KEY_W   = 16;
  localparam int COUNT_W = 16;
  localparam int ACT_W   = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_TAKE  = 2'd2
  } action_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CALC,
    ST_EMIT
  } state_t;

  // Everything the shared unit works out for one slot.
  typedef struct packed {
    logic [COUNT_W-1:0] new_count;
    logic [COUNT_W-1:0] removed;
    logic               enough;
  } alu_res_t;

endpackage

@@ design/kct_store.sv @@
// ----------------------------------------------------------------------------
// kct_store: slot memory of the keyed count table
// One write port and one registered read port over the key and count arrays.
// A per-slot valid bit, cleared at reset, makes an unwritten slot read as empty.
// ----------------------------------------------------------------------------
module kct_store #(
  parameter int SLOTS = 16,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [kct_pkg::KEY_W-1:0]   wr_key,
  input  logic [kct_pkg::COUNT_W-1:0] wr_count,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [kct_pkg::KEY_W-1:0]   rd_key,
  output logic [kct_pkg::COUNT_W-1:0] rd_count
);

  logic [kct_pkg::KEY_W-1:0]   key_mem   [SLOTS];
  logic [kct_pkg::COUNT_W-1:0] count_mem [SLOTS];
  logic [SLOTS-1:0]            vld_r;
  logic                        rd_vld_r;
  logic [kct_pkg::KEY_W-1:0]   rd_key_r;
  logic [kct_pkg::COUNT_W-1:0] rd_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]   <= wr_key;
      count_mem[wr_addr] <= wr_count;
    end
    rd_key_r   <= key_mem[rd_addr];
    rd_count_r <= count_mem[rd_addr];
  end

  // A slot never written reads as key zero and count zero.
  assign rd_key   = rd_vld_r ? rd_key_r   : '0;
  assign rd_count = rd_vld_r ? rd_count_r : '0;

endmodule

@@ design/kct_alu.sv @@
// ----------------------------------------------------------------------------
// kct_alu: shared add and subtract unit
// One 17-bit adder serves the saturating add, the take subtraction and the
// enough-present compare.
// ----------------------------------------------------------------------------
module kct_alu (
  input  kct_pkg::alu_op_t            op,
  input  logic [kct_pkg::COUNT_W-1:0] count,
  input  logic [kct_pkg::COUNT_W-1:0] amount,
  output kct_pkg::alu_res_t           res
);

  logic                        is_sub;
  logic [kct_pkg::COUNT_W:0]   operand_b;
  logic [kct_pkg::COUNT_W:0]   sum;
  logic                        carry;

  assign is_sub    = (op == kct_pkg::ALU_SUB);
  assign operand_b = is_sub ? {1'b1, ~amount} : {1'b0, amount};
  assign sum       = {1'b0, count} + operand_b + {{kct_pkg::COUNT_W{1'b0}}, is_sub};
  // For an add the top bit is the overflow; for a subtract it is the borrow.
  assign carry     = sum[kct_pkg::COUNT_W];

  always_comb begin
    res = '0;
    if (is_sub) begin
      res.enough    = !carry && (amount != '0);
      res.new_count = carry ? '0 : sum[kct_pkg::COUNT_W-1:0];
      res.removed   = carry ? count : amount;
    end else begin
      res.enough    = 1'b1;
      res.new_count = carry ? '1 : sum[kct_pkg::COUNT_W-1:0];
      res.removed   = '0;
    end
  end

endmodule

@@ design/keyed_count_table_unit.sv @@
// ----------------------------------------------------------------------------
// keyed_count_table_unit: keyed count table with add, query and take
// Top level: request sequencer, slot store and shared add/subtract unit.
// ----------------------------------------------------------------------------
// The table holds SLOTS slots of a 16-bit key and a 16-bit count; key zero
// marks an empty slot and slots are filled lowest first and never freed, so
// the occupied slots always form a prefix. Each request walks the store one
// slot per cycle through its single registered read port, stopping at the
// matching key, at the first empty slot or after the last slot. The input
// stalls until the sequencer is back in idle, so a new request is taken only
// once the previous one has handed its result to the output register.
// Requests with key zero or an unknown action, and queries of amount zero,
// skip the walk. The result sits in an output register, so the next request
// is taken while a result still waits downstream. All slots read as empty
// immediately after reset; there is no clearing pass.
// ----------------------------------------------------------------------------
module keyed_count_table_unit #(
  parameter int SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [kct_pkg::ACT_W-1:0]   in_action,
  input  logic [kct_pkg::KEY_W-1:0]   in_item_key,
  input  logic [kct_pkg::COUNT_W-1:0] in_amount_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_ok,
  output logic [kct_pkg::COUNT_W-1:0] out_amount_out
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  kct_pkg::state_t             state_r, state_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [kct_pkg::ACT_W-1:0]   act_r;
  logic [kct_pkg::KEY_W-1:0]   key_r;
  logic [kct_pkg::COUNT_W-1:0] amt_r;
  logic                        res_ok_r, res_ok_nxt;
  logic [kct_pkg::COUNT_W-1:0] res_amt_r, res_amt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_ok_r;
  logic [kct_pkg::COUNT_W-1:0] out_amount_r;

  logic                        in_accept;
  logic                        out_free;
  logic                        out_load;

  logic                        wr_en;
  logic [kct_pkg::KEY_W-1:0]   wr_key;
  logic [kct_pkg::COUNT_W-1:0] wr_count;
  logic [kct_pkg::KEY_W-1:0]   rd_key;
  logic [kct_pkg::COUNT_W-1:0] rd_count;

  kct_pkg::alu_op_t            alu_op;
  kct_pkg::alu_res_t           alu_res;

  // The read address always follows the next scan index, so the registered
  // read data in any cycle belongs to the slot at idx_r.
  kct_store #(
    .SLOTS(SLOTS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_key  (wr_key),
    .wr_count(wr_count),
    .rd_addr (idx_nxt),
    .rd_key  (rd_key),
    .rd_count(rd_count)
  );

  assign alu_op = (act_r == kct_pkg::ACT_ADD) ? kct_pkg::ALU_ADD : kct_pkg::ALU_SUB;

  kct_alu u_alu (
    .op    (alu_op),
    .count (rd_count),
    .amount(amt_r),
    .res   (alu_res)
  );

  assign in_stall  = (state_r != kct_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  // The output register can take a new result when empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    res_ok_nxt  = res_ok_r;
    res_amt_nxt = res_amt_r;
    wr_en       = 1'b0;
    wr_key      = key_r;
    wr_count    = amt_r;
    out_load    = 1'b0;

    unique case (state_r)
      kct_pkg::ST_IDLE: begin
        idx_nxt = '0;
        if (in_accept) begin
          res_ok_nxt  = 1'b0;
          res_amt_nxt = '0;
          // Requests that can change nothing and report nothing skip the walk.
          if (in_item_key == '0) begin
            state_nxt = kct_pkg::ST_EMIT;
          end else begin
            unique case (in_action) inside
              kct_pkg::ACT_ADD,
              kct_pkg::ACT_TAKE:  state_nxt = kct_pkg::ST_CHECK;
              kct_pkg::ACT_QUERY: state_nxt = (in_amount_in == '0) ? kct_pkg::ST_EMIT
                                                                    : kct_pkg::ST_CHECK;
              default:            state_nxt = kct_pkg::ST_EMIT;
            endcase
          end
        end
      end

      kct_pkg::ST_CHECK: begin
        if (rd_key == key_r) begin
          state_nxt = kct_pkg::ST_CALC;
        end else if (rd_key == '0) begin
          // First empty slot: the key is absent. An add claims this slot.
          if (act_r == kct_pkg::ACT_ADD) begin
            wr_en      = 1'b1;
            wr_count   = amt_r;
            res_ok_nxt = 1'b1;
          end
          state_nxt = kct_pkg::ST_EMIT;
        end else if (idx_r == LAST_IDX) begin
          // Table full and the key is not in it.
          state_nxt = kct_pkg::ST_EMIT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      kct_pkg::ST_CALC: begin
        if (act_r == kct_pkg::ACT_QUERY) begin
          res_ok_nxt = alu_res.enough;
        end else begin
          wr_en    = 1'b1;
          wr_count = alu_res.new_count;
          if (act_r == kct_pkg::ACT_ADD) begin
            res_ok_nxt = 1'b1;
          end else begin
            res_amt_nxt = alu_res.removed;
          end
        end
        state_nxt = kct_pkg::ST_EMIT;
      end

      kct_pkg::ST_EMIT: begin
        idx_nxt = '0;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = kct_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = kct_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kct_pkg::ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      act_r <= in_action;
      key_r <= in_item_key;
      amt_r <= in_amount_in;
    end
    res_ok_r  <= res_ok_nxt;
    res_amt_r <= res_amt_nxt;
    if (out_load) begin
      out_ok_r     <= res_ok_r;
      out_amount_r <= res_amt_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_amount_out = out_amount_r;

  // The store is only written while a request is being worked on.
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == kct_pkg::ST_CHECK || state_r == kct_pkg::ST_CALC))
    else $error("store written outside of a request");

  // An empty-slot marker is never stored as a key.
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_key != '0))
    else $error("key zero written to the store");

  // An accepted request always leaves the idle state at the next edge.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != kct_pkg::ST_IDLE))
    else $error("accepted request did not start");

  // A new result is loaded only when the output register can take it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_amount_r)))
    else $error("pending result overwritten");

endmodule
